[hw/rtl/kfh_pkg.sv]
// Shared types and constants of the keyframe Hermite path evaluator.
`default_nettype none
package kfh_pkg;

   // transaction kinds
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_EVAL  = 2'd1;
   localparam logic [1:0] FUNC_TAN   = 2'd2;

   // register indexes (byte address 8*i)
   localparam logic [1:0] REG_COUNT = 2'd0;
   localparam logic [1:0] REG_LOOP  = 2'd1;
   localparam logic [1:0] REG_START = 2'd2;
   localparam logic [1:0] REG_END   = 2'd3;

   // word slots of one entry in the vector store
   localparam logic [3:0] SLOT_POS  = 4'd0;
   localparam logic [3:0] SLOT_TIN  = 4'd3;
   localparam logic [3:0] SLOT_TOUT = 4'd6;

   // word_sel codes
   localparam logic [3:0] SEL_ARRIVAL = 4'd0;
   localparam logic [3:0] SEL_PAUSE   = 4'd1;
   localparam logic [3:0] SEL_VEC_LO  = 4'd2;
   localparam logic [3:0] SEL_VEC_HI  = 4'd10;

   localparam logic [5:0] MOD_STEPS = 6'd49;
   localparam logic [5:0] U_STEPS   = 6'd16;

   typedef struct packed {
      logic [1:0]         func;
      logic [3:0]         entry;
      logic [3:0]         word_sel;
      logic signed [47:0] word_value;
      logic signed [47:0] query_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               no_keyframes;
   } rsp_type;

   typedef struct packed {
      logic [4:0]         keyframe_count;
      logic               loop_enable;
      logic signed [47:0] start_time;
      logic signed [47:0] end_time;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [48:0] rem_init;
      logic [48:0] dividend;
      logic [48:0] divisor;
      logic [5:0]  steps;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [48:0] quotient;
      logic [48:0] remainder;
   } div_rsp_type;

endpackage
`default_nettype wire

[hw/rtl/kfh_csr.sv]
// APB-style configuration registers of the path evaluator.
`default_nettype none
module kfh_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [4:0]       csr_paddr,
   input  wire logic [63:0]      csr_pwdata,
   output logic      [63:0]      csr_prdata,
   output logic                  csr_pready,
   output kfh_pkg::cfg_type      cfg
);
   import kfh_pkg::*;

   cfg_type    cfg_ff;
   logic [1:0] idx;

   assign idx        = csr_paddr[4:3];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keyframe_count <= 5'd0;
         cfg_ff.loop_enable    <= 1'b0;
         cfg_ff.start_time     <= 48'sd0;
         cfg_ff.end_time       <= 48'sd655360;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_COUNT: cfg_ff.keyframe_count <= csr_pwdata[4:0];
            REG_LOOP:  cfg_ff.loop_enable    <= csr_pwdata[0];
            REG_START: cfg_ff.start_time     <= csr_pwdata[47:0];
            REG_END:   cfg_ff.end_time       <= csr_pwdata[47:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_COUNT: csr_prdata = {59'd0, cfg_ff.keyframe_count};
         REG_LOOP:  csr_prdata = {63'd0, cfg_ff.loop_enable};
         REG_START: csr_prdata = {{16{cfg_ff.start_time[47]}}, cfg_ff.start_time};
         REG_END:   csr_prdata = {{16{cfg_ff.end_time[47]}}, cfg_ff.end_time};
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/kfh_store.sv]
// Keyframe storage: time memory (arrival, pause) and vector memory (xyz words).
`default_nettype none
module kfh_store #(
   parameter int KEY_AW = 4
) (
   input  wire logic                     clock,
   input  wire logic                     t_we,
   input  wire logic [KEY_AW:0]          t_waddr,
   input  wire logic signed [39:0]       t_wdata,
   input  wire logic [KEY_AW:0]          t_raddr,
   output logic signed [39:0]            t_rdata,
   input  wire logic                     v_we,
   input  wire logic [KEY_AW+3:0]        v_waddr,
   input  wire logic signed [31:0]       v_wdata,
   input  wire logic [KEY_AW+3:0]        v_raddr,
   output logic signed [31:0]            v_rdata
);

   // time words at {entry, 0=arrival/1=pause}
   logic signed [39:0] time_mem [2**(KEY_AW+1)];
   // vector words at {entry, slot}
   logic signed [31:0] vec_mem [2**(KEY_AW+4)];
   logic signed [39:0] t_rdata_ff;
   logic signed [31:0] v_rdata_ff;

   always_ff @(posedge clock) begin
      if (t_we) time_mem[t_waddr] <= t_wdata;
      t_rdata_ff <= time_mem[t_raddr];
   end

   always_ff @(posedge clock) begin
      if (v_we) vec_mem[v_waddr] <= v_wdata;
      v_rdata_ff <= vec_mem[v_raddr];
   end

   assign t_rdata = t_rdata_ff;
   assign v_rdata = v_rdata_ff;

endmodule
`default_nettype wire

[hw/rtl/kfh_divider.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module kfh_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire kfh_pkg::div_cmd_type cmd,
   output kfh_pkg::div_rsp_type      rsp
);
   import kfh_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [48:0] rem_ff;
   logic [48:0] quo_ff;
   logic [48:0] dvs_ff;
   logic [49:0] trial;
   logic        ge;
   logic [49:0] diff;

   assign trial = {rem_ff, quo_ff[48]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
            rem_ff  <= cmd.rem_init;
            quo_ff  <= cmd.dividend;
            dvs_ff  <= cmd.divisor;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[48:0] : trial[48:0];
            quo_ff <= {quo_ff[47:0], ge};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule
`default_nettype wire

[hw/rtl/keyframe_hermite_path_evaluator_unit.sv]
// Top level: keyframe Hermite path evaluator sequencer around the keyframe store.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_data (req_type)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_data (rsp_type)
//  csr     | in        | psel/penable/pready    | paddr, pwdata, prdata (64 bit)
//
// One transaction at a time: a word write, a tangent reset or an evaluate.
// An evaluate runs the key search, the modulo divider when the time wraps,
// and for a segment the divider for u (only in the open case), the basis
// steps and 12 terms of read, multiply, accumulate.
// Reset is synchronous; the keyframe memories are not cleared.
// A result waiting under rsp_stall does not block new transactions; only the
// next evaluate holds at its end until the output register is free.
`default_nettype none
module keyframe_hermite_path_evaluator_unit #(
   parameter int MAX_KEYS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kfh_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kfh_pkg::rsp_type       rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [4:0]        csr_paddr,
   input  wire logic [63:0]       csr_pwdata,
   output logic      [63:0]       csr_prdata,
   output logic                   csr_pready
);
   import kfh_pkg::*;

   localparam int KW = $clog2(MAX_KEYS);
   localparam int NW = $clog2(MAX_KEYS + 1);
   localparam logic signed [53:0] ONE48 = 54'sh1000000000000;
   localparam logic signed [53:0] RND17 = 54'sh20000;
   localparam logic signed [65:0] RND29 = 66'sh20000000;
   localparam logic signed [65:0] MAX32 = 66'sh7fffffff;
   localparam logic signed [65:0] MIN32 = -66'sh80000000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_MOD_WAIT, ST_ARD, ST_ACHK, ST_PCHK, ST_NCHK,
      ST_U_WAIT, ST_BASIS1, ST_BASIS2, ST_BASIS3, ST_TERM_RD, ST_TERM_MUL,
      ST_TERM_ACC, ST_PP_RD, ST_PP_CAP, ST_TR_RDQ, ST_TR_RDP, ST_TR_W1,
      ST_TR_W2, ST_RESULT
   } state_type;

   state_type          state_ff;
   req_type            item_ff;
   logic [KW-1:0]      k_ff, pk_ff, p_ff, q_ff;
   logic [1:0]         comp_ff, term_ff;
   logic [48:0]        rel_ff, w_ff;
   logic               neg_ff, empty_ff;
   logic signed [39:0] arr_ff;
   logic signed [40:0] ms_ff;
   logic [16:0]        u_ff;
   logic [33:0]        u2_ff;
   logic [50:0]        u3_ff;
   logic signed [31:0] b_ff [4];
   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff;
   logic signed [31:0] res_ff [3];
   logic signed [31:0] qv_ff, d_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   cfg_type            cfg;
   div_cmd_type        div_cmd;
   div_rsp_type        div_rsp;

   logic                t_we, v_we;
   logic [KW:0]         t_waddr, t_raddr;
   logic [KW+3:0]       v_waddr, v_raddr;
   logic signed [39:0]  t_wdata, tq;
   logic signed [31:0]  v_wdata, vq;

   // ---------------------------------------------------------------- helpers
   function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
      if (v > 48'sh7fffffffff)       return 40'sh7fffffffff;
      else if (v < -48'sh8000000000) return -40'sh8000000000;
      else                           return v[39:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sh7fffffff)       return 32'sh7fffffff;
      else if (v < -48'sh80000000) return -32'sh80000000;
      else                         return v[31:0];
   endfunction

   function automatic logic [KW+3:0] vaddr(input logic [KW-1:0] idx,
                                           input logic [3:0] slot);
      return {idx, slot};
   endfunction

   // ---------------------------------------------------------------- submodules
   kfh_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   kfh_store #(.KEY_AW(KW)) u_store (
      .clock, .t_we, .t_waddr, .t_wdata, .t_raddr, .t_rdata(tq),
      .v_we, .v_waddr, .v_wdata, .v_raddr, .v_rdata(vq)
   );

   kfh_divider u_div (.clock, .reset, .cmd(div_cmd), .rsp(div_rsp));

   // ---------------------------------------------------------------- datapath
   logic [NW-1:0]      n_cnt;
   logic signed [48:0] dt, wl;
   logic               t_lo, t_hi, t_le, wl_pos, outside, use_mod;
   logic [48:0]        mag, rel_mod;
   logic signed [50:0] rel_ext, tq_ext, msn_ext, msf_ext, span, num;
   logic signed [40:0] ms_new;
   logic               span_pos, num_pos, num_ge, seg_div;
   logic signed [53:0] u3e, u2e, ue;
   logic signed [53:0] hb [4];
   logic signed [31:0] b_sel;
   logic signed [63:0] prod_c;
   logic signed [65:0] sum, rnd;
   logic signed [31:0] res_round;
   logic signed [32:0] tdiff;
   logic signed [32:0] half;
   logic [3:0]         slot_sel;

   assign n_cnt = (int'(cfg.keyframe_count) > MAX_KEYS) ? NW'(MAX_KEYS)
                                                         : NW'(cfg.keyframe_count);
   assign dt      = {item_ff.query_time[47], item_ff.query_time}
                  - {cfg.start_time[47], cfg.start_time};
   assign wl      = {cfg.end_time[47], cfg.end_time} - {cfg.start_time[47], cfg.start_time};
   assign t_lo    = item_ff.query_time < cfg.start_time;
   assign t_le    = item_ff.query_time <= cfg.start_time;
   assign t_hi    = item_ff.query_time > cfg.end_time;
   assign outside = t_lo || t_hi;
   assign wl_pos  = !wl[48] && (wl != 49'sd0);
   assign use_mod = cfg.loop_enable && wl_pos;
   assign mag     = dt[48] ? 49'(-dt) : 49'(dt);
   // floor modulo: a negative offset with a remainder folds back from the top
   assign rel_mod = (neg_ff && div_rsp.remainder != 49'd0) ? w_ff - div_rsp.remainder
                                                            : div_rsp.remainder;

   assign rel_ext  = signed'({2'b00, rel_ff});
   assign tq_ext   = {{11{tq[39]}}, tq};
   assign ms_new   = {arr_ff[39], arr_ff} + {tq[39], tq};
   assign msn_ext  = {{10{ms_new[40]}}, ms_new};
   assign msf_ext  = {{10{ms_ff[40]}}, ms_ff};
   assign span     = tq_ext - msf_ext;
   assign num      = rel_ext - msf_ext;
   assign span_pos = !span[50] && (span != 51'sd0);
   assign num_pos  = !num[50] && (num != 51'sd0);
   assign num_ge   = num >= span;
   assign seg_div  = span_pos && num_pos && !num_ge;

   // Hermite basis in Q48, rounded to Q30
   assign u3e = signed'({3'b000, u3_ff});
   assign u2e = signed'({4'b0000, u2_ff, 16'h0000});
   assign ue  = signed'({5'b00000, u_ff, 32'h0});
   assign hb[0] = ((u3e <<< 1) - (u2e <<< 1) - u2e + ONE48 + RND17) >>> 18;
   assign hb[1] = (u3e - (u2e <<< 1) + ue + RND17) >>> 18;
   assign hb[2] = ((u2e <<< 1) + u2e - (u3e <<< 1) + RND17) >>> 18;
   assign hb[3] = (u3e - u2e + RND17) >>> 18;

   assign b_sel     = b_ff[term_ff];
   assign prod_c    = b_sel * vq;
   assign sum       = acc_ff + {{2{prod_ff[63]}}, prod_ff};
   assign rnd       = (sum + RND29) >>> 30;
   assign res_round = (rnd > MAX32) ? 32'sh7fffffff
                    : (rnd < MIN32) ? -32'sh80000000 : rnd[31:0];

   assign tdiff = {qv_ff[31], qv_ff} - {vq[31], vq};
   assign half  = tdiff >>> 1;

   always_comb begin
      unique case (term_ff)
         2'd0:    slot_sel = SLOT_POS  + {2'b00, comp_ff};
         2'd1:    slot_sel = SLOT_TOUT + {2'b00, comp_ff};
         2'd2:    slot_sel = SLOT_POS  + {2'b00, comp_ff};
         default: slot_sel = SLOT_TIN  + {2'b00, comp_ff};
      endcase
   end

   // memory ports and divider command
   always_comb begin
      t_we     = 1'b0;
      t_waddr  = {KW'(item_ff.entry), item_ff.word_sel[0]};
      t_wdata  = sat40(item_ff.word_value);
      v_we     = 1'b0;
      v_waddr  = vaddr(KW'(item_ff.entry), item_ff.word_sel - SEL_VEC_LO);
      v_wdata  = sat32(item_ff.word_value);
      t_raddr  = {k_ff, 1'b0};
      v_raddr  = vaddr(pk_ff, SLOT_POS + {2'b00, comp_ff});
      div_cmd  = '0;
      unique case (state_ff)
         ST_DECODE: begin
            if (item_ff.func == FUNC_WRITE && int'(item_ff.entry) < MAX_KEYS) begin
               t_we = (item_ff.word_sel == SEL_ARRIVAL) || (item_ff.word_sel == SEL_PAUSE);
               v_we = (item_ff.word_sel >= SEL_VEC_LO) && (item_ff.word_sel <= SEL_VEC_HI);
            end
            div_cmd.start    = (item_ff.func == FUNC_EVAL) && (int'(n_cnt) > 1)
                               && outside && use_mod;
            div_cmd.dividend = mag;
            div_cmd.divisor  = wl;
            div_cmd.steps    = MOD_STEPS;
         end
         ST_ACHK: t_raddr = {k_ff, 1'b1};
         ST_PCHK: t_raddr = {KW'(k_ff + 1'b1), 1'b0};
         ST_NCHK: begin
            t_raddr          = {KW'(k_ff + 1'b1), 1'b1};
            div_cmd.start    = (rel_ext < tq_ext) && seg_div;
            div_cmd.rem_init = num[48:0];
            div_cmd.divisor  = 49'(span[41:0]);
            div_cmd.steps    = U_STEPS;
         end
         ST_TERM_RD: v_raddr = vaddr(term_ff[1] ? KW'(k_ff + 1'b1) : k_ff, slot_sel);
         ST_TR_RDQ:  v_raddr = vaddr(q_ff, SLOT_POS + {2'b00, comp_ff});
         ST_TR_RDP:  v_raddr = vaddr(p_ff, SLOT_POS + {2'b00, comp_ff});
         ST_TR_W1: begin
            v_we    = 1'b1;
            v_waddr = vaddr(KW'(item_ff.entry), SLOT_TIN + {2'b00, comp_ff});
            v_wdata = half[31:0];
         end
         ST_TR_W2: begin
            v_we    = 1'b1;
            v_waddr = vaddr(KW'(item_ff.entry), SLOT_TOUT + {2'b00, comp_ff});
            v_wdata = d_ff;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the result state reloads the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_RESULT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               comp_ff  <= 2'd0;
               term_ff  <= 2'd0;
               k_ff     <= '0;
               empty_ff <= 1'b0;
               neg_ff   <= dt[48];
               w_ff     <= wl;
               rel_ff   <= dt;
               unique case (item_ff.func)
                  FUNC_EVAL: begin
                     if (n_cnt == '0) begin
                        empty_ff  <= 1'b1;
                        res_ff[0] <= 32'sd0;
                        res_ff[1] <= 32'sd0;
                        res_ff[2] <= 32'sd0;
                        state_ff  <= ST_RESULT;
                     end else if (int'(n_cnt) == 1) begin
                        pk_ff    <= '0;
                        state_ff <= ST_PP_RD;
                     end else if (outside && use_mod) begin
                        state_ff <= ST_MOD_WAIT;
                     end else if (outside) begin
                        pk_ff    <= t_le ? '0 : KW'(n_cnt - 1'b1);
                        state_ff <= ST_PP_RD;
                     end else begin
                        state_ff <= ST_ARD;
                     end
                  end
                  FUNC_TAN: begin
                     p_ff <= (item_ff.entry == 4'd0) ? '0 : KW'(item_ff.entry - 4'd1);
                     q_ff <= (int'(item_ff.entry) < int'(n_cnt) - 1)
                             ? KW'(5'(item_ff.entry) + 5'd1) : KW'(n_cnt - 1'b1);
                     state_ff <= (int'(item_ff.entry) >= int'(n_cnt)) ? ST_IDLE
                                                                       : ST_TR_RDQ;
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_MOD_WAIT: begin
               if (div_rsp.done) begin
                  rel_ff   <= rel_mod;
                  state_ff <= ST_ARD;
               end
            end
            ST_ARD: state_ff <= ST_ACHK;
            ST_ACHK: begin
               arr_ff <= tq;
               if (rel_ext < tq_ext) begin
                  pk_ff    <= '0;
                  state_ff <= ST_PP_RD;
               end else begin
                  state_ff <= ST_PCHK;
               end
            end
            ST_PCHK: begin
               ms_ff <= ms_new;
               if (rel_ext < msn_ext) begin
                  pk_ff    <= k_ff;
                  state_ff <= ST_PP_RD;
               end else if (int'(k_ff) + 1 < int'(n_cnt)) begin
                  state_ff <= ST_NCHK;
               end else begin
                  pk_ff    <= KW'(n_cnt - 1'b1);
                  state_ff <= ST_PP_RD;
               end
            end
            ST_NCHK: begin
               if (rel_ext < tq_ext) begin
                  // segment k: u from the span, divider only for the open case
                  if (!span_pos || !num_pos) begin
                     u_ff     <= 17'd0;
                     state_ff <= ST_BASIS1;
                  end else if (num_ge) begin
                     u_ff     <= 17'd65536;
                     state_ff <= ST_BASIS1;
                  end else begin
                     state_ff <= ST_U_WAIT;
                  end
               end else begin
                  arr_ff   <= tq;
                  k_ff     <= KW'(k_ff + 1'b1);
                  state_ff <= ST_PCHK;
               end
            end
            ST_U_WAIT: begin
               if (div_rsp.done) begin
                  u_ff     <= {1'b0, div_rsp.quotient[15:0]};
                  state_ff <= ST_BASIS1;
               end
            end
            ST_BASIS1: begin
               u2_ff    <= u_ff * u_ff;
               state_ff <= ST_BASIS2;
            end
            ST_BASIS2: begin
               u3_ff    <= u2_ff * u_ff;
               state_ff <= ST_BASIS3;
            end
            ST_BASIS3: begin
               b_ff[0]  <= hb[0][31:0];
               b_ff[1]  <= hb[1][31:0];
               b_ff[2]  <= hb[2][31:0];
               b_ff[3]  <= hb[3][31:0];
               acc_ff   <= 66'sd0;
               state_ff <= ST_TERM_RD;
            end
            ST_TERM_RD: state_ff <= ST_TERM_MUL;
            ST_TERM_MUL: begin
               prod_ff  <= prod_c;
               state_ff <= ST_TERM_ACC;
            end
            ST_TERM_ACC: begin
               if (term_ff == 2'd3) begin
                  res_ff[comp_ff] <= res_round;
                  acc_ff          <= 66'sd0;
                  term_ff         <= 2'd0;
                  comp_ff         <= comp_ff + 2'd1;
                  state_ff        <= (comp_ff == 2'd2) ? ST_RESULT : ST_TERM_RD;
               end else begin
                  acc_ff   <= sum;
                  term_ff  <= term_ff + 2'd1;
                  state_ff <= ST_TERM_RD;
               end
            end
            ST_PP_RD: state_ff <= ST_PP_CAP;
            ST_PP_CAP: begin
               res_ff[comp_ff] <= vq;
               comp_ff         <= comp_ff + 2'd1;
               state_ff        <= (comp_ff == 2'd2) ? ST_RESULT : ST_PP_RD;
            end
            ST_TR_RDQ: state_ff <= ST_TR_RDP;
            ST_TR_RDP: begin
               qv_ff    <= vq;
               state_ff <= ST_TR_W1;
            end
            ST_TR_W1: begin
               d_ff     <= half[31:0];
               state_ff <= ST_TR_W2;
            end
            ST_TR_W2: begin
               comp_ff  <= comp_ff + 2'd1;
               state_ff <= (comp_ff == 2'd2) ? ST_IDLE : ST_TR_RDQ;
            end
            ST_RESULT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.pos_x        <= res_ff[0];
                  rsp_ff.pos_y        <= res_ff[1];
                  rsp_ff.pos_z        <= res_ff[2];
                  rsp_ff.no_keyframes <= empty_ff;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- assertions
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while one is in flight");

   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_MOD_WAIT || state_ff == ST_U_WAIT))
      else $error("divider finished with no sequencer waiting");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESULT)
      else $error("result raised outside the result state");

   a_vec_write_src: assert property (@(posedge clock) disable iff (reset)
      v_we |-> (state_ff == ST_DECODE || state_ff == ST_TR_W1 || state_ff == ST_TR_W2))
      else $error("vector memory written outside a write step");

endmodule
`default_nettype wire
